[rtl/core/mlcr_pkg.sv]
// Shared constants and types for the multispecies life cell rule block.
package mlcr_pkg;

  localparam int SPECIES_BITS_DEF = 4;
  localparam int NUM_NEIGHBORS    = 8;
  localparam int CNT_W            = 4;
  localparam int CFG_IDX_W        = 2;
  localparam int CFG_DATA_W       = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_UNDER_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OVER_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIRTH_COUNT = 2'd2;

  localparam logic [CFG_DATA_W-1:0] UNDER_LIMIT_RST = 4'd2;
  localparam logic [CFG_DATA_W-1:0] OVER_LIMIT_RST  = 4'd3;
  localparam logic [CFG_DATA_W-1:0] BIRTH_COUNT_RST = 4'd3;

  // What one lane reports: whether its neighbour counts toward a species,
  // and how many equal live neighbours lie at or before it in scan order.
  typedef struct packed {
    logic             hit;
    logic [CNT_W-1:0] cnt;
  } lane_res_t;

endpackage

[rtl/core/mlcr_lane.sv]
// One neighbour lane: running count of its own species up to its scan position.
module mlcr_lane
  import mlcr_pkg::*;
#(
  parameter int LANE         = 0,
  parameter int SPECIES_BITS = SPECIES_BITS_DEF
) (
  input  logic [NUM_NEIGHBORS-1:0]              alive,
  input  logic [NUM_NEIGHBORS*SPECIES_BITS-1:0] species,
  output lane_res_t                             res
);

  logic [SPECIES_BITS-1:0] own;
  logic                    hit;
  logic [CNT_W-1:0]        cnt;

  assign own = species[LANE*SPECIES_BITS +: SPECIES_BITS];
  assign hit = alive[LANE] && (own != '0);

  always_comb begin
    cnt = '0;
    for (int j = 0; j <= LANE; j++) begin
      if (alive[j] && (species[j*SPECIES_BITS +: SPECIES_BITS] == own)) begin
        cnt = cnt + CNT_W'(1);
      end
    end
  end

  assign res.hit = hit;
  assign res.cnt = hit ? cnt : '0;

endmodule

[rtl/core/mlcr_merge.sv]
// Merge tree: picks the earliest lane holding the highest running count.
module mlcr_merge
  import mlcr_pkg::*;
#(
  parameter int SPECIES_BITS = SPECIES_BITS_DEF
) (
  input  lane_res_t                             res [NUM_NEIGHBORS],
  input  logic [NUM_NEIGHBORS*SPECIES_BITS-1:0] species,
  output logic [SPECIES_BITS-1:0]               winner
);

  logic [CNT_W-1:0]        c0 [8];
  logic [SPECIES_BITS-1:0] s0 [8];
  logic [CNT_W-1:0]        c1 [4];
  logic [SPECIES_BITS-1:0] s1 [4];
  logic [CNT_W-1:0]        c2 [2];
  logic [SPECIES_BITS-1:0] s2 [2];

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      c0[k] = res[k].cnt;
      s0[k] = res[k].hit ? species[k*SPECIES_BITS +: SPECIES_BITS] : '0;
    end
    // The left operand is always earlier in scan order, so a tie keeps it.
    for (int k = 0; k < 4; k++) begin
      if (c0[2*k+1] > c0[2*k]) begin
        c1[k] = c0[2*k+1];
        s1[k] = s0[2*k+1];
      end else begin
        c1[k] = c0[2*k];
        s1[k] = s0[2*k];
      end
    end
    for (int k = 0; k < 2; k++) begin
      if (c1[2*k+1] > c1[2*k]) begin
        c2[k] = c1[2*k+1];
        s2[k] = s1[2*k+1];
      end else begin
        c2[k] = c1[2*k];
        s2[k] = s1[2*k];
      end
    end
    if (c2[1] > c2[0]) begin
      winner = s2[1];
    end else begin
      winner = (c2[0] == '0) ? '0 : s2[0];
    end
  end

endmodule

[rtl/core/multispecies_life_cell_rule_top.sv]
// Top level of the multispecies life cell rule: lanes, merge and handshake.
// Path: a transaction passes the stage-one register, then the output register.
// Throughput: one transaction per cycle; both pipeline stages advance together
// whenever the output register is empty or being taken.
// Reset: synchronous active-low rst_n empties the pipeline and reloads the
// rule registers with under limit 2, over limit 3 and birth count 3.
module multispecies_life_cell_rule_top
  import mlcr_pkg::*;
#(
  parameter int SPECIES_BITS = SPECIES_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_center_alive,
  input  logic [SPECIES_BITS-1:0]               in_center_species,
  input  logic [NUM_NEIGHBORS-1:0]              in_neighbor_alive,
  input  logic [NUM_NEIGHBORS*SPECIES_BITS-1:0] in_neighbor_species,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_next_alive,
  output logic [SPECIES_BITS-1:0]               out_next_species,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]                  cfg_index,
  input  logic [CFG_DATA_W-1:0]                 cfg_data
);

  // Rule registers. The port always takes a write; an index past the last
  // register is accepted and dropped.
  logic [CFG_DATA_W-1:0] under_r, over_r, birth_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      under_r <= UNDER_LIMIT_RST;
      over_r  <= OVER_LIMIT_RST;
      birth_r <= BIRTH_COUNT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_UNDER_LIMIT: under_r <= cfg_data;
        CFG_OVER_LIMIT:  over_r  <= cfg_data;
        CFG_BIRTH_COUNT: birth_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Flow control. The output register frees itself when taken, and the lane
  // stage moves on whenever the output register can take its contents; while a
  // finished result waits, a new transaction enters only an empty lane stage.
  logic s1_v_r, out_v_r;
  logic out_adv, s1_adv;

  assign out_adv  = !out_v_r || out_ready;
  assign s1_adv   = out_adv;
  assign in_ready = !s1_v_r || s1_adv;

  // Stage one: live neighbour count, the survival or birth decision and the
  // eight lanes, each counting equal species up to its own scan position.
  logic [CNT_W-1:0] n_cnt;
  logic             survive, born;
  lane_res_t        lane_res [NUM_NEIGHBORS];

  always_comb begin
    n_cnt = '0;
    for (int k = 0; k < NUM_NEIGHBORS; k++) begin
      n_cnt = n_cnt + CNT_W'(in_neighbor_alive[k]);
    end
  end

  // A live cell dies below the under limit. Hitting either limit keeps it,
  // and otherwise it dies only above the over limit.
  assign survive = in_center_alive && !(n_cnt < under_r) &&
                   ((n_cnt == under_r) || (n_cnt == over_r) || !(n_cnt > over_r));
  assign born    = !in_center_alive && (n_cnt == birth_r);

  for (genvar g = 0; g < NUM_NEIGHBORS; g++) begin : g_lane
    mlcr_lane #(
      .LANE         (g),
      .SPECIES_BITS (SPECIES_BITS)
    ) u_lane (
      .alive   (in_neighbor_alive),
      .species (in_neighbor_species),
      .res     (lane_res[g])
    );
  end

  logic                                  s1_center_alive_r;
  logic                                  s1_survive_r, s1_born_r;
  logic [SPECIES_BITS-1:0]               s1_center_sp_r;
  logic [NUM_NEIGHBORS*SPECIES_BITS-1:0] s1_nsp_r;
  lane_res_t                             s1_res_r [NUM_NEIGHBORS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_center_alive_r <= in_center_alive;
      s1_survive_r      <= survive;
      s1_born_r         <= born;
      s1_center_sp_r    <= in_center_species;
      s1_nsp_r          <= in_neighbor_species;
      s1_res_r          <= lane_res;
    end
  end

  // Stage two: the merge tree finds the dominant species for a birth.
  logic [SPECIES_BITS-1:0] winner;

  mlcr_merge #(
    .SPECIES_BITS (SPECIES_BITS)
  ) u_merge (
    .res     (s1_res_r),
    .species (s1_nsp_r),
    .winner  (winner)
  );

  // A live cell keeps its species even when it dies; a newborn takes the
  // winner; a dead cell that stays dead reports species zero.
  logic                    out_alive_nxt;
  logic [SPECIES_BITS-1:0] out_sp_nxt;
  logic                    out_alive_r;
  logic [SPECIES_BITS-1:0] out_sp_r;

  always_comb begin
    out_alive_nxt = s1_survive_r || s1_born_r;
    if (s1_center_alive_r) begin
      out_sp_nxt = s1_center_sp_r;
    end else if (s1_born_r) begin
      out_sp_nxt = winner;
    end else begin
      out_sp_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_adv) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_v_r) begin
      out_alive_r <= out_alive_nxt;
      out_sp_r    <= out_sp_nxt;
    end
  end

  assign out_valid        = out_v_r;
  assign out_next_alive   = out_alive_r;
  assign out_next_species = out_sp_r;

endmodule

[rtl/core/mlcr_checker.sv]
// Port-level checker for the multispecies life cell rule top, with its bind.
module mlcr_checker
  import mlcr_pkg::*;
#(
  parameter int SPECIES_BITS = SPECIES_BITS_DEF
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic                    out_next_alive,
  input logic [SPECIES_BITS-1:0] out_next_species
);

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // The input side only stalls when the output holds an untaken result.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output back-pressure");

  // A stalled result keeps its payload until it is taken.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable({out_next_alive, out_next_species}))
    else $error("result payload changed while stalled");

  // A stalled result stays presented.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

endmodule

bind multispecies_life_cell_rule_top mlcr_checker #(
  .SPECIES_BITS (SPECIES_BITS)
) u_mlcr_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_ready         (in_ready),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_next_alive   (out_next_alive),
  .out_next_species (out_next_species)
);
